>>> rtl/barometer_compensation_macros.svh
`ifndef BAROMETER_COMPENSATION_MACROS_SVH
`define BAROMETER_COMPENSATION_MACROS_SVH

// Condition must hold in the same cycle.
`define BCMP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("barometer compensation check failed");

// Condition must hold in the following cycle.
`define BCMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("barometer compensation check failed");

`endif

>>> rtl/bcmp_pkg.sv
package bcmp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AC1,
        CFG_AC2,
        CFG_AC3,
        CFG_AC4,
        CFG_AC5,
        CFG_AC6,
        CFG_B1_B2,
        CFG_MC_MD
    } bcmp_cfg_e;

    // Divider geometry
    localparam int TDIV_NUM_W = 27;
    localparam int TDIV_DEN_W = 17;
    localparam int PDIV_NUM_W = 32;
    localparam int PDIV_DEN_W = 17;

    localparam logic signed [31:0] B6_OFS    = 32'sd4000;
    localparam logic signed [31:0] X3_OFS    = 32'sd32768;
    localparam logic [15:0]        B7_SCALE  = 16'd50000;
    localparam logic signed [15:0] P_C1      = 16'sd3038;
    localparam logic signed [15:0] P_C2      = -16'sd7357;
    localparam logic signed [31:0] P_C3      = 32'sd3791;
    localparam logic signed [31:0] PRESS_MAX = 32'sd4194303;
    localparam logic signed [31:0] TEMP_MAX  = 32'sd32767;
    localparam logic signed [31:0] TEMP_MIN  = -32'sd32768;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] raw_press;
    } bcmp_in_t;

    typedef struct packed {
        logic signed [15:0] temp_tenths;
        logic [21:0]        press_pa;
        logic               div_error;
    } bcmp_out_t;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
    } bcmp_cal_t;

    typedef struct packed {
        logic valid;
        logic err;
    } bcmp_ctl_t;

    typedef struct packed {
        logic signed [31:0] b6;
        logic signed [15:0] temp;
        logic [15:0]        up;
    } bcmp_tmid_t;

endpackage

>>> rtl/barometer_compensation.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_data   (raw_temp, raw_press)
// out       output     out_valid/out_ready  out_data  (temp_tenths, press_pa, div_error)
// cfg       input      cfg_we               cfg_index, cfg_wdata
//
// One item enters per cycle while in_ready is high; 70 register stages lie
// between in and out, set by the two bit-per-stage dividers (27 and 32 stages)
// plus the multiply stages around them.
// Reset clears all valid bits and the calibration registers to zero.
// When out_valid is high and out_ready low the whole pipeline holds and in_ready
// drops; nothing in flight is lost or repeated.
module barometer_compensation (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  bcmp_pkg::bcmp_in_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output bcmp_pkg::bcmp_out_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [bcmp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcmp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    bcmp_pkg::bcmp_cal_t  cal_reg;
    bcmp_pkg::bcmp_ctl_t  mid_ctl;
    bcmp_pkg::bcmp_tmid_t mid_data;
    logic                 en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= '0;
        else if (cfg_we)
        begin
            unique case (bcmp_pkg::bcmp_cfg_e'(cfg_index))
                bcmp_pkg::CFG_AC1:   cal_reg.ac1 <= cfg_wdata[15:0];
                bcmp_pkg::CFG_AC2:   cal_reg.ac2 <= cfg_wdata[15:0];
                bcmp_pkg::CFG_AC3:   cal_reg.ac3 <= cfg_wdata[15:0];
                bcmp_pkg::CFG_AC4:   cal_reg.ac4 <= cfg_wdata[15:0];
                bcmp_pkg::CFG_AC5:   cal_reg.ac5 <= cfg_wdata[15:0];
                bcmp_pkg::CFG_AC6:   cal_reg.ac6 <= cfg_wdata[15:0];
                bcmp_pkg::CFG_B1_B2:
                begin
                    cal_reg.b1 <= cfg_wdata[31:16];
                    cal_reg.b2 <= cfg_wdata[15:0];
                end
                bcmp_pkg::CFG_MC_MD:
                begin
                    cal_reg.mc <= cfg_wdata[31:16];
                    cal_reg.md <= cfg_wdata[15:0];
                end
                default: ;
            endcase
        end
    end

    // Advance every stage unless a finished item is stuck at the output
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    bcmp_temp u_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .in_item  (in_data),
        .cal      (cal_reg),
        .mid_ctl  (mid_ctl),
        .mid_data (mid_data)
    );

    bcmp_press u_press (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .mid_ctl  (mid_ctl),
        .mid_data (mid_data),
        .cal      (cal_reg),
        .res_vld  (out_valid),
        .res      (out_data)
    );

endmodule

>>> rtl/bcmp_div.sv
module bcmp_div #(
    parameter int NumW  = 32,
    parameter int DenW  = 17,
    parameter int SideW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [NumW-1:0]  num,
    input  logic [DenW-1:0]  den,
    input  logic [SideW-1:0] side_in,
    output logic             out_vld,
    output logic [NumW-1:0]  quo,
    output logic [SideW-1:0] side_out
);

    logic [NumW-1:0]  word_s [NumW+1];
    logic [DenW-1:0]  rem_s  [NumW+1];
    logic [DenW-1:0]  den_s  [NumW+1];
    logic [SideW-1:0] side_s [NumW+1];
    logic             vld_s  [NumW+1];

    assign word_s[0] = num;
    assign rem_s[0]  = '0;
    assign den_s[0]  = den;
    assign side_s[0] = side_in;
    assign vld_s[0]  = in_vld;

    // One quotient bit per stage; quotient bits shift into the numerator word
    for (genvar k = 0; k < NumW; k++) begin : g_stage
        logic [DenW:0]    shifted;
        logic [DenW:0]    diff;
        logic             ge;
        logic [NumW-1:0]  word_next;
        logic [DenW-1:0]  rem_next;
        logic [NumW-1:0]  word_reg;
        logic [DenW-1:0]  rem_reg;
        logic [DenW-1:0]  den_reg;
        logic [SideW-1:0] side_reg;
        logic             vld_reg;

        always_comb
        begin
            shifted   = {rem_s[k], word_s[k][NumW-1]};
            diff      = shifted - {1'b0, den_s[k]};
            ge        = (shifted >= {1'b0, den_s[k]});
            word_next = {word_s[k][NumW-2:0], ge};
            rem_next  = ge ? diff[DenW-1:0] : shifted[DenW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_s[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                word_reg <= word_next;
                rem_reg  <= rem_next;
                den_reg  <= den_s[k];
                side_reg <= side_s[k];
            end
        end

        assign word_s[k+1] = word_reg;
        assign rem_s[k+1]  = rem_reg;
        assign den_s[k+1]  = den_reg;
        assign side_s[k+1] = side_reg;
        assign vld_s[k+1]  = vld_reg;
    end

    assign out_vld  = vld_s[NumW];
    assign quo      = word_s[NumW];
    assign side_out = side_s[NumW];

endmodule

>>> rtl/bcmp_temp.sv
module bcmp_temp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  bcmp_pkg::bcmp_in_t     in_item,
    input  bcmp_pkg::bcmp_cal_t    cal,
    output bcmp_pkg::bcmp_ctl_t    mid_ctl,
    output bcmp_pkg::bcmp_tmid_t   mid_data
);

    localparam int NW = bcmp_pkg::TDIV_NUM_W;
    localparam int DW = bcmp_pkg::TDIV_DEN_W;
    localparam int SW = 2 + 17 + 16;

    // S1: raw product of (UT - AC6) * AC5
    logic signed [16:0] diff_ut;
    logic signed [33:0] prod_x1;
    logic               s1_vld_reg;
    logic [31:0]        s1_prod_reg;
    logic [15:0]        s1_up_reg;

    assign diff_ut = $signed({1'b0, in_item.raw_temp}) - $signed({1'b0, cal.ac6});
    assign prod_x1 = diff_ut * $signed({1'b0, cal.ac5});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= prod_x1[31:0];
            s1_up_reg   <= in_item.raw_press;
        end
    end

    // S2: divisor X1 + MD, split into sign and magnitude
    logic signed [16:0] x1_next;
    logic signed [17:0] div_next;
    logic signed [17:0] div_neg;
    logic signed [16:0] mc_neg;
    logic [15:0]        mc_mag;
    logic               s2_vld_reg;
    logic [NW-1:0]      s2_num_reg;
    logic [DW-1:0]      s2_den_reg;
    logic [SW-1:0]      s2_side_reg;

    always_comb
    begin
        x1_next  = s1_prod_reg[31:15];
        div_next = 18'(x1_next) + 18'(cal.md);
        div_neg  = -div_next;
        mc_neg   = -17'(cal.mc);
        mc_mag   = cal.mc[15] ? mc_neg[15:0] : cal.mc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_num_reg  <= {mc_mag, 11'b0};
            s2_den_reg  <= div_next[17] ? div_neg[DW-1:0] : div_next[DW-1:0];
            s2_side_reg <= {cal.mc[15] ^ div_next[17], (div_next == '0), x1_next, s1_up_reg};
        end
    end

    logic          dv_vld;
    logic [NW-1:0] dv_quo;
    logic [SW-1:0] dv_side;

    bcmp_div #(
        .NumW  (NW),
        .DenW  (DW),
        .SideW (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s2_vld_reg),
        .num      (s2_num_reg),
        .den      (s2_den_reg),
        .side_in  (s2_side_reg),
        .out_vld  (dv_vld),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    // S3: B5, temperature and B6
    logic               q_neg;
    logic               d_zero;
    logic signed [16:0] x1_d;
    logic signed [NW:0] x2;
    logic signed [31:0] b5;
    logic signed [31:0] t_full;
    logic signed [15:0] t_sat;
    bcmp_pkg::bcmp_ctl_t  ctl_reg;
    bcmp_pkg::bcmp_tmid_t data_reg;

    always_comb
    begin
        q_neg  = dv_side[SW-1];
        d_zero = dv_side[SW-2];
        x1_d   = dv_side[32:16];
        x2     = q_neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
        b5     = 32'(x1_d) + 32'(x2);
        t_full = (b5 + 32'sd8) >>> 4;
        if (t_full > bcmp_pkg::TEMP_MAX)
            t_sat = 16'sh7FFF;
        else if (t_full < bcmp_pkg::TEMP_MIN)
            t_sat = -16'sh8000;
        else
            t_sat = t_full[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
        begin
            ctl_reg.valid <= dv_vld;
            ctl_reg.err   <= d_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg.b6   <= b5 - bcmp_pkg::B6_OFS;
            data_reg.temp <= t_sat;
            data_reg.up   <= dv_side[15:0];
        end
    end

    assign mid_ctl  = ctl_reg;
    assign mid_data = data_reg;

endmodule

>>> rtl/bcmp_press.sv
module bcmp_press (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  bcmp_pkg::bcmp_ctl_t   mid_ctl,
    input  bcmp_pkg::bcmp_tmid_t  mid_data,
    input  bcmp_pkg::bcmp_cal_t   cal,
    output logic                  res_vld,
    output bcmp_pkg::bcmp_out_t   res
);

    localparam int NW = bcmp_pkg::PDIV_NUM_W;
    localparam int DW = bcmp_pkg::PDIV_DEN_W;
    localparam int SW = 2 + 16;

    // S4: B6 squared, AC2 * B6, AC3 * B6
    logic signed [63:0] sq_full;
    logic signed [47:0] mac2_full;
    logic signed [47:0] mac3_full;
    bcmp_pkg::bcmp_ctl_t s4_ctl_reg;
    logic [31:0]         s4_sq_reg;
    logic [31:0]         s4_mac2_reg;
    logic [31:0]         s4_mac3_reg;
    logic signed [15:0]  s4_t_reg;
    logic [15:0]         s4_up_reg;

    assign sq_full   = mid_data.b6 * mid_data.b6;
    assign mac2_full = cal.ac2 * mid_data.b6;
    assign mac3_full = cal.ac3 * mid_data.b6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_ctl_reg <= '0;
        else if (en)
            s4_ctl_reg <= mid_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_sq_reg   <= sq_full[31:0];
            s4_mac2_reg <= mac2_full[31:0];
            s4_mac3_reg <= mac3_full[31:0];
            s4_t_reg    <= mid_data.temp;
            s4_up_reg   <= mid_data.up;
        end
    end

    // S5: scale the products
    bcmp_pkg::bcmp_ctl_t s5_ctl_reg;
    logic signed [31:0]  s5_b6sq_reg;
    logic signed [31:0]  s5_x2a_reg;
    logic signed [31:0]  s5_x1b_reg;
    logic signed [15:0]  s5_t_reg;
    logic [15:0]         s5_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_ctl_reg <= '0;
        else if (en)
            s5_ctl_reg <= s4_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_b6sq_reg <= $signed(s4_sq_reg) >>> 12;
            s5_x2a_reg  <= $signed(s4_mac2_reg) >>> 11;
            s5_x1b_reg  <= $signed(s4_mac3_reg) >>> 13;
            s5_t_reg    <= s4_t_reg;
            s5_up_reg   <= s4_up_reg;
        end
    end

    // S6: B2 and B1 times the scaled square
    logic signed [47:0]  mb2_full;
    logic signed [47:0]  mb1_full;
    bcmp_pkg::bcmp_ctl_t s6_ctl_reg;
    logic signed [31:0]  s6_mb2_reg;
    logic signed [31:0]  s6_mb1_reg;
    logic signed [31:0]  s6_x2a_reg;
    logic signed [31:0]  s6_x1b_reg;
    logic signed [15:0]  s6_t_reg;
    logic [15:0]         s6_up_reg;

    assign mb2_full = cal.b2 * s5_b6sq_reg;
    assign mb1_full = cal.b1 * s5_b6sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_ctl_reg <= '0;
        else if (en)
            s6_ctl_reg <= s5_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_mb2_reg <= mb2_full[31:0];
            s6_mb1_reg <= mb1_full[31:0];
            s6_x2a_reg <= s5_x2a_reg;
            s6_x1b_reg <= s5_x1b_reg;
            s6_t_reg   <= s5_t_reg;
            s6_up_reg  <= s5_up_reg;
        end
    end

    // S7: B3 and the B4 multiplicand
    logic signed [31:0]  x3a;
    logic signed [31:0]  b3_sum;
    logic signed [31:0]  b3_next;
    logic signed [31:0]  x3b;
    bcmp_pkg::bcmp_ctl_t s7_ctl_reg;
    logic signed [31:0]  s7_b3_reg;
    logic [31:0]         s7_u_reg;
    logic signed [15:0]  s7_t_reg;
    logic [15:0]         s7_up_reg;

    always_comb
    begin
        x3a     = (s6_mb2_reg >>> 11) + s6_x2a_reg;
        b3_sum  = (32'(cal.ac1) <<< 2) + x3a + 32'sd2;
        // divide by four, rounding toward zero
        b3_next = (b3_sum + (b3_sum[31] ? 32'sd3 : 32'sd0)) >>> 2;
        x3b     = ((s6_mb1_reg >>> 16) + s6_x1b_reg + 32'sd2) >>> 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_ctl_reg <= '0;
        else if (en)
            s7_ctl_reg <= s6_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_b3_reg <= b3_next;
            s7_u_reg  <= x3b + bcmp_pkg::X3_OFS;
            s7_t_reg  <= s6_t_reg;
            s7_up_reg <= s6_up_reg;
        end
    end

    // S8: B4 and B7
    logic [47:0]         b4_full;
    logic [31:0]         up_b3;
    logic [47:0]         b7_full;
    bcmp_pkg::bcmp_ctl_t s8_ctl_reg;
    logic [DW-1:0]       s8_b4_reg;
    logic [31:0]         s8_b7_reg;
    logic signed [15:0]  s8_t_reg;

    always_comb
    begin
        b4_full = 48'(cal.ac4) * 48'(s7_u_reg);
        up_b3   = {16'b0, s7_up_reg} - s7_b3_reg;
        b7_full = 48'(up_b3) * 48'(bcmp_pkg::B7_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_ctl_reg <= '0;
        else if (en)
            s8_ctl_reg <= s7_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_b4_reg <= b4_full[31:15];
            s8_b7_reg <= b7_full[31:0];
            s8_t_reg  <= s7_t_reg;
        end
    end

    // Large B7 divides first and doubles after
    logic          big;
    logic [NW-1:0] num;
    logic [SW-1:0] side_in;
    logic          dv_vld;
    logic [NW-1:0] dv_quo;
    logic [SW-1:0] dv_side;

    always_comb
    begin
        big     = s8_b7_reg[31];
        num     = big ? s8_b7_reg : {s8_b7_reg[30:0], 1'b0};
        side_in = {big, s8_ctl_reg.err | (s8_b4_reg == '0), s8_t_reg};
    end

    bcmp_div #(
        .NumW  (NW),
        .DenW  (DW),
        .SideW (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s8_ctl_reg.valid),
        .num      (num),
        .den      (s8_b4_reg),
        .side_in  (side_in),
        .out_vld  (dv_vld),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    // S10: (p >> 8) squared and -7357 * p
    logic signed [31:0]  p_div;
    logic signed [23:0]  p_hi;
    logic signed [47:0]  psq_full;
    logic signed [47:0]  pc2_full;
    bcmp_pkg::bcmp_ctl_t s10_ctl_reg;
    logic signed [31:0]  s10_p_reg;
    logic signed [31:0]  s10_psq_reg;
    logic signed [31:0]  s10_pc2_reg;
    logic signed [15:0]  s10_t_reg;

    always_comb
    begin
        p_div    = dv_side[SW-1] ? {dv_quo[NW-2:0], 1'b0} : dv_quo;
        p_hi     = p_div[31:8];
        psq_full = p_hi * p_hi;
        pc2_full = p_div * bcmp_pkg::P_C2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s10_ctl_reg <= '0;
        else if (en)
        begin
            s10_ctl_reg.valid <= dv_vld;
            s10_ctl_reg.err   <= dv_side[SW-2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_p_reg   <= p_div;
            s10_psq_reg <= psq_full[31:0];
            s10_pc2_reg <= pc2_full[31:0];
            s10_t_reg   <= dv_side[15:0];
        end
    end

    // S11: scale the square by 3038
    logic signed [47:0]  pc1_full;
    bcmp_pkg::bcmp_ctl_t s11_ctl_reg;
    logic signed [31:0]  s11_p_reg;
    logic signed [31:0]  s11_pc1_reg;
    logic signed [31:0]  s11_x2_reg;
    logic signed [15:0]  s11_t_reg;

    assign pc1_full = s10_psq_reg * bcmp_pkg::P_C1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s11_ctl_reg <= '0;
        else if (en)
            s11_ctl_reg <= s10_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_p_reg   <= s10_p_reg;
            s11_pc1_reg <= pc1_full[31:0];
            s11_x2_reg  <= s10_pc2_reg >>> 16;
            s11_t_reg   <= s10_t_reg;
        end
    end

    // S12: final correction, saturation and error zeroing
    logic signed [31:0]  corr;
    logic signed [31:0]  p_fin;
    logic [21:0]         p_sat;
    bcmp_pkg::bcmp_out_t res_next;
    logic                res_vld_reg;
    bcmp_pkg::bcmp_out_t res_reg;

    always_comb
    begin
        corr  = ((s11_pc1_reg >>> 16) + s11_x2_reg + bcmp_pkg::P_C3) >>> 4;
        p_fin = s11_p_reg + corr;
        if (p_fin[31])
            p_sat = '0;
        else if (p_fin > bcmp_pkg::PRESS_MAX)
            p_sat = '1;
        else
            p_sat = p_fin[21:0];
        if (s11_ctl_reg.err)
            res_next = '{temp_tenths: '0, press_pa: '0, div_error: 1'b1};
        else
            res_next = '{temp_tenths: s11_t_reg, press_pa: p_sat, div_error: 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (en)
            res_vld_reg <= s11_ctl_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res_vld = res_vld_reg;
    assign res     = res_reg;

endmodule

>>> rtl/bcmp_chk.sv
`include "barometer_compensation_macros.svh"

module bcmp_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input bcmp_pkg::bcmp_in_t              in_data,
    input logic                            out_valid,
    input logic                            out_ready,
    input bcmp_pkg::bcmp_out_t             out_data
);

    `BCMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `BCMP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))
    `BCMP_ASSERT_SAME(a_ready_stall, 1'b1, in_ready == (!out_valid || out_ready))
    // temperature and pressure fields sit above the error bit
    `BCMP_ASSERT_SAME(a_err_zero, out_valid && out_data.div_error, out_data[38:1] == '0)

endmodule

bind barometer_compensation bcmp_chk u_bcmp_chk (.*);

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    bcmp_pkg::bcmp_in_t in_data;
    logic out_valid;
    logic out_ready;
    bcmp_pkg::bcmp_out_t out_data;
    logic cfg_we;
    logic [bcmp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bcmp_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // pipeline depth of the block
    localparam int PIPE_CYCLES = 70;

    barometer_compensation DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0] ac4, ac5, ac6;

    bcmp_pkg::bcmp_out_t reading_q[$];
    int errors;
    bit stall_enable;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor shift of a signed 32-bit word
    function automatic logic signed [31:0] asr(logic signed [31:0] v, int s);
        return v >>> s;
    endfunction

    function automatic bcmp_pkg::bcmp_out_t compensate(logic [15:0] ut, logic [15:0] up);
        bcmp_pkg::bcmp_out_t r;
        logic signed [31:0] x1, x2, x3, b3, b5, b6, b6sq, t, p, dv, tmp;
        logic signed [63:0] wide;
        logic [31:0] b4, b7, pu;
        logic [63:0] uw;
        r = '0;
        x1 = asr(($signed({16'd0, ut}) - $signed({16'd0, ac6})) * $signed({16'd0, ac5}), 15);
        dv = x1 + 32'(md);
        if (dv == 0)
        begin
            r.div_error = 1'b1;
            return r;
        end
        wide = 64'(signed'(32'(mc) * 2048)) / 64'(dv);
        x2 = wide[31:0];
        b5 = x1 + x2;
        t = asr(b5 + 8, 4);
        b6 = b5 - 4000;
        b6sq = asr(b6 * b6, 12);
        x1 = asr(32'(b2) * b6sq, 11);
        x2 = asr(32'(ac2) * b6, 11);
        x3 = x1 + x2;
        tmp = 32'(ac1) * 4 + x3 + 2;
        b3 = tmp / 4;
        x1 = asr(32'(ac3) * b6, 13);
        x2 = asr(32'(b1) * b6sq, 16);
        x3 = asr(x1 + x2 + 2, 2);
        tmp = x3 + 32768;
        uw = 64'(ac4) * 64'(unsigned'(tmp));
        // the product wraps to 32 bits before the shift
        b4 = uw[31:0] >> 15;
        if (b4 == 0)
        begin
            r.div_error = 1'b1;
            return r;
        end
        b7 = (32'(up) - unsigned'(b3)) * 32'd50000;
        if (b7 < 32'h8000_0000)
            pu = (b7 * 2) / b4;
        else
            pu = (b7 / b4) * 2;
        p = signed'(pu);
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * 3038, 16);
        x2 = asr(-32'sd7357 * p, 16);
        p = p + asr(x1 + x2 + 3791, 4);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        if (p < 0) p = 0;
        if (p > 4194303) p = 4194303;
        r.temp_tenths = t[15:0];
        r.press_pa = p[21:0];
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // the caller drops cfg_we after the last write
    task automatic write_cal(bcmp_pkg::bcmp_cfg_e idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            bcmp_pkg::CFG_AC1: ac1 = val[15:0];
            bcmp_pkg::CFG_AC2: ac2 = val[15:0];
            bcmp_pkg::CFG_AC3: ac3 = val[15:0];
            bcmp_pkg::CFG_AC4: ac4 = val[15:0];
            bcmp_pkg::CFG_AC5: ac5 = val[15:0];
            bcmp_pkg::CFG_AC6: ac6 = val[15:0];
            bcmp_pkg::CFG_B1_B2: {b1, b2} = val;
            bcmp_pkg::CFG_MC_MD: {mc, md} = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (reading_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 5) @(posedge clk);
    endtask

    task automatic set_cal(logic [15:0] a1, a2, a3, a4, a5, a6, logic [31:0] bb, mm);
        drain();
        write_cal(bcmp_pkg::CFG_AC1, {16'($urandom), a1});
        write_cal(bcmp_pkg::CFG_AC2, {16'd0, a2});
        write_cal(bcmp_pkg::CFG_AC3, {16'd0, a3});
        write_cal(bcmp_pkg::CFG_AC4, {16'd0, a4});
        write_cal(bcmp_pkg::CFG_AC5, {16'd0, a5});
        write_cal(bcmp_pkg::CFG_AC6, {16'd0, a6});
        write_cal(bcmp_pkg::CFG_B1_B2, bb);
        write_cal(bcmp_pkg::CFG_MC_MD, mm);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(logic [15:0] ut, logic [15:0] up, bit with_gap);
        int g;
        bcmp_pkg::bcmp_in_t item;
        if (with_gap)
        begin
            g = gap_len();
            if (g != 0)
            begin
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
        item.raw_temp = ut;
        item.raw_press = up;
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
        reading_q.push_back(compensate(ut, up));
    endtask

    task automatic set_datasheet_cal();
        set_cal(16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
                {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    endtask

    task automatic test_datasheet();
        set_datasheet_cal();
        send_sample(16'd27898, 16'd23843, 1'b0);
        send_sample(16'd0, 16'd0, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 16'd0, 1'b0);
        send_sample(16'd0, 16'hFFFF, 1'b0);
        send_sample(16'h5555, 16'hAAAA, 1'b0);
        send_sample(16'hAAAA, 16'h5555, 1'b0);
    endtask

    task automatic test_divisor_zero();
        // all zero calibration: temperature divisor is zero
        set_cal(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
        send_sample(16'd1234, 16'd4321, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 1'b0);
        // md nonzero, ac4 zero: pressure divisor zero
        set_cal(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd1);
        send_sample(16'd100, 16'd200, 1'b0);
        // x1 + md == 0 with nonzero x1: ut=ac6+32768, ac5=1 gives x1=1
        set_cal(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 32'd0, {16'd5, 16'hFFFF});
        send_sample(16'd32768, 16'd500, 1'b0);
        send_sample(16'd32769, 16'd500, 1'b0);
    endtask

    task automatic test_extremes();
        set_cal(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                32'h7FFF_7FFF, 32'h7FFF_0001);
        send_sample(16'd0, 16'd0, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'h8000, 16'h0001, 1'b0);
        set_cal(16'h8000, 16'h8000, 16'h8000, 16'h0001, 16'h0001, 16'h0000,
                32'h8000_8000, 32'h8000_8000);
        send_sample(16'd0, 16'd0, 1'b0);
        send_sample(16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 16'h8000, 1'b0);
        // large ac4; both a small and a large up push b7 past the top bit
        set_cal(16'd408, 16'd0, 16'd0, 16'hFFFF, 16'd32757, 16'd23153, 32'd0,
                {16'd0, 16'd2868});
        send_sample(16'd27898, 16'd0, 1'b0);
        send_sample(16'd27898, 16'hFFFF, 1'b0);
    endtask

    task automatic test_random();
        int n;
        int k;
        for (n = 0; n < 1900; n++)
        begin
            if (n % 300 == 0)
            begin
                k = $urandom_range(0, 2);
                if (k == 0)
                    set_datasheet_cal();
                else
                    set_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), $urandom, $urandom);
            end
            if (n == 950)
                drain();
            stall_enable = (n % 400) < 300;
            if ($urandom_range(0, 3) == 0)
                send_sample(16'($urandom), 16'($urandom), stall_enable);
            else
                send_sample(16'($urandom_range(20000, 35000)),
                            16'($urandom_range(15000, 40000)), stall_enable);
        end
    endtask

    // receiver: random stalls and result check
    initial
    begin
        bcmp_pkg::bcmp_out_t want;
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = stall_enable ? gap_len() : 0;
            if (g != 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (reading_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    want = reading_q.pop_front();
                    if (out_data.temp_tenths !== want.temp_tenths)
                    begin
                        $display("%0t: temp_tenths expected %0d actual %0d", $time,
                                 want.temp_tenths, out_data.temp_tenths);
                        errors++;
                    end
                    if (out_data.press_pa !== want.press_pa)
                    begin
                        $display("%0t: press_pa expected %0d actual %0d", $time,
                                 want.press_pa, out_data.press_pa);
                        errors++;
                    end
                    if (out_data.div_error !== want.div_error)
                    begin
                        $display("%0t: div_error expected %0b actual %0b", $time,
                                 want.div_error, out_data.div_error);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("barometer_compensation verification failed");
        $finish;
    end

    initial
    begin
        errors = 0;
        stall_enable = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        {ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md} = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_datasheet();
        test_divisor_zero();
        test_extremes();
        test_random();
        drain();
        if (errors == 0)
            $display("barometer_compensation verification clean");
        else
            $display("barometer_compensation verification failed");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/bcmp_pkg.sv
rtl/bcmp_div.sv
rtl/bcmp_temp.sv
rtl/bcmp_press.sv
rtl/barometer_compensation.sv
rtl/bcmp_chk.sv
bench/tb_top.sv
